[sv/rvu_pkg.sv]
// Package for the ray vector unit: shared constants, mode codes, the
// side record that travels down the cell chains, and the saturation helper.
// No dependencies.
`default_nettype none

package rvu_pkg;

  localparam int RVU_FRAC_BITS = 16;
  localparam int RVU_RAD_W     = 64;
  localparam int RVU_ROOT_W    = 32;

  typedef logic [2:0] mode_t;

  localparam mode_t MODE_DIR     = 3'd0;
  localparam mode_t MODE_REFRACT = 3'd1;
  localparam mode_t MODE_REFLECT = 3'd2;
  localparam mode_t MODE_POINT   = 3'd3;
  localparam mode_t MODE_LENGTH  = 3'd4;

  // Everything a request still needs after the square root chain.
  typedef struct packed {
    mode_t             mode;
    logic              tir;
    logic              zero;
    logic              sh;
    logic [2:0]        neg;
    logic [2:0][29:0]  mn;
    logic [31:0]       qsc;
    logic [2:0][31:0]  qsa;
    logic [2:0][31:0]  b;
    logic [2:0][31:0]  res;
  } rvu_side_t;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
    logic [30:0]        length;
    logic               tir;
  } rvu_res_t;

  function automatic logic signed [31:0] sat32(input logic signed [65:0] x);
    logic signed [31:0] r;
    if (x > 66'sd2147483647) begin
      r = 32'sh7FFFFFFF;
    end else if (x < -66'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = x[31:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

[sv/rvu_ifs.sv]
// Valid/ready channel interfaces for the ray vector unit: the request
// channel and the result channel. No dependencies.
`default_nettype none

interface rvu_req_if;
  logic               valid;
  logic               ready;
  logic [2:0]         mode;
  logic signed [31:0] vec_a_x;
  logic signed [31:0] vec_a_y;
  logic signed [31:0] vec_a_z;
  logic signed [31:0] vec_b_x;
  logic signed [31:0] vec_b_y;
  logic signed [31:0] vec_b_z;
  logic signed [31:0] scalar_in;

  modport source(output valid, mode, vec_a_x, vec_a_y, vec_a_z, vec_b_x, vec_b_y,
                 vec_b_z, scalar_in, input ready);
  modport sink(input valid, mode, vec_a_x, vec_a_y, vec_a_z, vec_b_x, vec_b_y,
               vec_b_z, scalar_in, output ready);
endinterface

interface rvu_rsp_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] res_x;
  logic signed [31:0] res_y;
  logic signed [31:0] res_z;
  logic [30:0]        res_length;
  logic               total_internal;

  modport source(output valid, res_x, res_y, res_z, res_length, total_internal,
                 input ready);
  modport sink(input valid, res_x, res_y, res_z, res_length, total_internal,
               output ready);
endinterface

`default_nettype wire

[sv/rvu_sqrt_cell.sv]
// One cell of the square root chain: settles one root bit per cycle while adv is high.
// Depends on rvu_pkg.
`default_nettype none

module rvu_sqrt_cell import rvu_pkg::*; #(
  parameter int STEP = 0
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  adv,
  input  logic                  in_valid,
  input  logic [RVU_RAD_W-1:0]  in_rem,
  input  logic [RVU_ROOT_W-1:0] in_root,
  input  rvu_side_t             in_side,
  output logic                  out_valid,
  output logic [RVU_RAD_W-1:0]  out_rem,
  output logic [RVU_ROOT_W-1:0] out_root,
  output rvu_side_t             out_side
);

  localparam int TW = RVU_RAD_W + 2;

  logic [TW-1:0] trial;
  logic          take;

  // Trial value is (2*root + 2^STEP) * 2^STEP.
  assign trial = (TW'(in_root) << (STEP + 1)) + (TW'(1) << (2 * STEP));
  assign take  = TW'(in_rem) >= trial;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_rem  <= take ? RVU_RAD_W'(TW'(in_rem) - trial) : in_rem;
      out_root <= take ? (in_root | (RVU_ROOT_W'(1) << STEP)) : in_root;
      out_side <= in_side;
    end
  end

endmodule

`default_nettype wire

[sv/rvu_div_cell.sv]
// One cell of the three-lane restoring divider chain: one quotient bit
// per lane per cycle while adv is high. Depends on rvu_pkg.
`default_nettype none

module rvu_div_cell import rvu_pkg::*; #(
  parameter int FRAC_BITS = RVU_FRAC_BITS,
  parameter int STEP      = 0
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            adv,
  input  logic                            in_valid,
  input  logic [RVU_ROOT_W-1:0]           in_len,
  input  logic [2:0][FRAC_BITS+32:0]      in_rem,
  input  logic [2:0][FRAC_BITS:0]         in_quo,
  input  rvu_side_t                       in_side,
  output logic                            out_valid,
  output logic [RVU_ROOT_W-1:0]           out_len,
  output logic [2:0][FRAC_BITS+32:0]      out_rem,
  output logic [2:0][FRAC_BITS:0]         out_quo,
  output rvu_side_t                       out_side
);

  localparam int RW = FRAC_BITS + 33;
  localparam int QW = FRAC_BITS + 1;

  logic [RW-1:0] dvs;

  assign dvs = RW'(in_len) << STEP;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        if (in_rem[i] >= dvs) begin
          out_rem[i] <= in_rem[i] - dvs;
          out_quo[i] <= in_quo[i] | (QW'(1) << STEP);
        end else begin
          out_rem[i] <= in_rem[i];
          out_quo[i] <= in_quo[i];
        end
      end
      out_len  <= in_len;
      out_side <= in_side;
    end
  end

endmodule

`default_nettype wire

[sv/ray_vector_unit.sv]
// Ray vector unit top level: front-end arithmetic stages, the square root
// cell chain, the divider cell chain and the result buffer.
// Depends on rvu_pkg, rvu_ifs, rvu_sqrt_cell and rvu_div_cell.
`default_nettype none

// The unit takes one request per clock while the pipeline is not held and
// returns exactly one result per request, in order. Each request selects a
// direction (normalized b - a), a refraction of a at normal b with index
// ratio scalar_in, a reflection of a at b, the point b + scalar_in * a, or
// the length of b - a, all in signed fixed point with FRAC_BITS fraction
// bits; results saturate to the 32-bit range, and a refraction whose k term
// is negative returns a zero vector with total_internal set. The pipeline has
// 11 front-end stages, 32 cells of square root (one root bit each), FRAC_BITS
// + 1 cells of division (one quotient bit each), 2 post stages and the output
// buffer; those two cell chains make up most of its depth. Throughput is one
// request per cycle while the pipeline is not held. A two-entry output buffer
// lets the unit keep taking requests while one result waits; the whole
// pipeline holds only when both entries are full and the consumer is not
// taking a result. No request is taken while reset is asserted.
module ray_vector_unit import rvu_pkg::*; #(
  parameter int FRAC_BITS = RVU_FRAC_BITS
) (
  input  logic      clk,
  input  logic      rst,
  rvu_req_if.sink   req,
  rvu_rsp_if.source rsp
);

  localparam int RW = FRAC_BITS + 33;
  localparam int QW = FRAC_BITS + 1;
  localparam int ND = FRAC_BITS + 2;
  localparam logic signed [65:0] ONE = 66'sd1 <<< FRAC_BITS;

  // Front-end values that never enter the cell chains.
  typedef struct packed {
    logic [29:0]      mx;
    logic [2:0][31:0] m4;
    logic [31:0]      k;
  } rvu_front_t;

  logic        adv;
  logic [10:0] v;

  // Stage 1: request capture.
  mode_t              s1_mode;
  logic signed [31:0] s1_a [3];
  logic signed [31:0] s1_b [3];
  logic signed [31:0] s1_s;

  // Stage 2: first products and exact differences.
  mode_t              s2_mode;
  logic signed [31:0] s2_a [3];
  logic signed [31:0] s2_b [3];
  logic signed [31:0] s2_s;
  logic signed [63:0] s2_pab [3];
  logic signed [63:0] s2_psa [3];
  logic signed [63:0] s2_pss;
  logic signed [32:0] s2_d [3];

  // Stage 3: dot product, scaled products and magnitudes.
  mode_t              s3_mode;
  logic signed [31:0] s3_a [3];
  logic signed [31:0] s3_b [3];
  logic signed [31:0] s3_s;
  logic signed [31:0] s3_dot;
  logic signed [31:0] s3_qsa [3];
  logic signed [31:0] s3_qss;
  logic [32:0]        s3_mag [3];
  logic [2:0]         s3_neg;

  logic [32:0] c4_mx;
  logic [1:0]  c4_rs;
  logic        c4_sh;

  // Stages 4 to 11 carry the side record plus stage-local values.
  rvu_side_t  p4, p5, p6, p7, p8, p9, p10, p11;
  rvu_front_t f4, f5, f6, f7, f8, f9;
  logic signed [31:0] s4_a [3];
  logic signed [31:0] s4_s, s4_c, s4_dn, s4_qss;
  logic signed [31:0] s5_a [3];
  logic signed [31:0] s5_qss;
  logic signed [63:0] s5_pcc, s5_psc;
  logic signed [63:0] s5_pbd [3];
  logic signed [31:0] s6_qss, s6_t1;
  logic signed [63:0] s7_pk;
  logic [63:0]        s10_sq [3];
  logic [31:0]        s10_k;
  logic [RVU_RAD_W-1:0] s11_rad;

  // Square root chain.
  logic                  sq_v    [RVU_ROOT_W+1];
  logic [RVU_RAD_W-1:0]  sq_rem  [RVU_ROOT_W+1];
  logic [RVU_ROOT_W-1:0] sq_root [RVU_ROOT_W+1];
  rvu_side_t             sq_side [RVU_ROOT_W+1];

  // Divider chain.
  logic                  dv_v    [ND];
  logic [RVU_ROOT_W-1:0] dv_len  [ND];
  logic [2:0][RW-1:0]    dv_rem  [ND];
  logic [2:0][QW-1:0]    dv_quo  [ND];
  rvu_side_t             dv_side [ND];

  // Post stages.
  logic                  va, vb;
  logic signed [31:0]    a_coef;
  logic [RVU_ROOT_W-1:0] a_root, b_root;
  logic [2:0][QW-1:0]    a_quo, b_quo;
  rvu_side_t             a_side, b_side;
  logic signed [63:0]    b_pcb [3];

  // Result buffer.
  rvu_res_t    fmt;
  rvu_res_t    q0, q1;
  logic [1:0]  cnt;
  logic        push, pop;

  assign adv       = (cnt != 2'd2) || rsp.ready;
  assign req.ready = adv && !rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (adv) begin
      v <= {v[9:0], req.valid};
    end
  end

  // Stage 1.
  always_ff @(posedge clk) begin
    if (adv) begin
      s1_mode <= req.mode;
      s1_a[0] <= req.vec_a_x;
      s1_a[1] <= req.vec_a_y;
      s1_a[2] <= req.vec_a_z;
      s1_b[0] <= req.vec_b_x;
      s1_b[1] <= req.vec_b_y;
      s1_b[2] <= req.vec_b_z;
      s1_s    <= req.scalar_in;
    end
  end

  // Stage 2.
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        s2_pab[i] <= s1_a[i] * s1_b[i];
        s2_psa[i] <= s1_s * s1_a[i];
        s2_d[i]   <= 33'(s1_b[i]) - 33'(s1_a[i]);
      end
      s2_pss  <= s1_s * s1_s;
      s2_mode <= s1_mode;
      s2_a    <= s1_a;
      s2_b    <= s1_b;
      s2_s    <= s1_s;
    end
  end

  // Stage 3.
  always_ff @(posedge clk) begin
    if (adv) begin
      s3_dot <= sat32(66'(s2_pab[0] >>> FRAC_BITS) + 66'(s2_pab[1] >>> FRAC_BITS)
                      + 66'(s2_pab[2] >>> FRAC_BITS));
      for (int i = 0; i < 3; i++) begin
        s3_qsa[i] <= sat32(66'(s2_psa[i] >>> FRAC_BITS));
        s3_neg[i] <= s2_d[i][32];
        s3_mag[i] <= s2_d[i][32] ? 33'(-s2_d[i]) : 33'(s2_d[i]);
      end
      s3_qss  <= sat32(66'(s2_pss >>> FRAC_BITS));
      s3_mode <= s2_mode;
      s3_a    <= s2_a;
      s3_b    <= s2_b;
      s3_s    <= s2_s;
    end
  end

  // Stage 4: coarse right shift for normalization, length prescale, c term.
  always_comb begin
    c4_mx = s3_mag[0];
    if (s3_mag[1] > c4_mx) begin
      c4_mx = s3_mag[1];
    end
    if (s3_mag[2] > c4_mx) begin
      c4_mx = s3_mag[2];
    end
    priority if (c4_mx[32]) begin
      c4_rs = 2'd3;
    end else if (c4_mx[31]) begin
      c4_rs = 2'd2;
    end else if (c4_mx[30]) begin
      c4_rs = 2'd1;
    end else begin
      c4_rs = 2'd0;
    end
    c4_sh = |{s3_mag[0][32:31], s3_mag[1][32:31], s3_mag[2][32:31]};
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p4      <= '0;
      p4.mode <= s3_mode;
      p4.neg  <= s3_neg;
      p4.zero <= (c4_mx == '0);
      p4.sh   <= c4_sh;
      f4.k    <= '0;
      for (int i = 0; i < 3; i++) begin
        p4.mn[i]  <= 30'(s3_mag[i] >> c4_rs);
        p4.qsa[i] <= s3_qsa[i];
        p4.b[i]   <= s3_b[i];
        f4.m4[i]  <= 32'(s3_mag[i] >> c4_sh);
      end
      f4.mx  <= 30'(c4_mx >> c4_rs);
      s4_c   <= sat32(-66'(s3_dot));
      s4_dn  <= s3_dot;
      s4_qss <= s3_qss;
      s4_a   <= s3_a;
      s4_s   <= s3_s;
    end
  end

  // Stage 5: second products; normalize step of 16.
  always_ff @(posedge clk) begin
    if (adv) begin
      p5 <= p4;
      f5 <= f4;
      if (f4.mx < 30'd16384) begin
        f5.mx <= f4.mx << 16;
        for (int i = 0; i < 3; i++) begin
          p5.mn[i] <= p4.mn[i] << 16;
        end
      end
      for (int i = 0; i < 3; i++) begin
        s5_pbd[i] <= $signed(p4.b[i]) * s4_dn;
      end
      s5_pcc <= s4_c * s4_c;
      s5_psc <= s4_s * s4_c;
      s5_qss <= s4_qss;
      s5_a   <= s4_a;
    end
  end

  // Stage 6: reflection and point results, refraction terms; step of 8.
  always_ff @(posedge clk) begin
    if (adv) begin
      p6 <= p5;
      f6 <= f5;
      if (f5.mx < 30'd4194304) begin
        f6.mx <= f5.mx << 8;
        for (int i = 0; i < 3; i++) begin
          p6.mn[i] <= p5.mn[i] << 8;
        end
      end
      p6.qsc <= sat32(66'(s5_psc >>> FRAC_BITS));
      for (int i = 0; i < 3; i++) begin
        if (p5.mode == MODE_REFLECT) begin
          p6.res[i] <= sat32(66'(s5_a[i]) - 66'(sat32(66'(s5_pbd[i] >>> FRAC_BITS)))
                             - 66'(sat32(66'(s5_pbd[i] >>> FRAC_BITS))));
        end else if (p5.mode == MODE_POINT) begin
          p6.res[i] <= sat32(66'($signed(p5.b[i])) + 66'($signed(p5.qsa[i])));
        end else begin
          p6.res[i] <= '0;
        end
      end
      s6_t1  <= sat32(ONE - 66'(sat32(66'(s5_pcc >>> FRAC_BITS))));
      s6_qss <= s5_qss;
    end
  end

  // Stage 7: s^2 times (1 - c^2); step of 4.
  always_ff @(posedge clk) begin
    if (adv) begin
      p7 <= p6;
      f7 <= f6;
      if (f6.mx < 30'd67108864) begin
        f7.mx <= f6.mx << 4;
        for (int i = 0; i < 3; i++) begin
          p7.mn[i] <= p6.mn[i] << 4;
        end
      end
      s7_pk <= s6_qss * s6_t1;
    end
  end

  // Stage 8: refraction term k; step of 2.
  always_ff @(posedge clk) begin
    if (adv) begin
      p8 <= p7;
      f8 <= f7;
      if (f7.mx < 30'd268435456) begin
        f8.mx <= f7.mx << 2;
        for (int i = 0; i < 3; i++) begin
          p8.mn[i] <= p7.mn[i] << 2;
        end
      end
      f8.k <= sat32(ONE - 66'(sat32(66'(s7_pk >>> FRAC_BITS))));
    end
  end

  // Stage 9: last step of 1; total internal reflection flag.
  always_ff @(posedge clk) begin
    if (adv) begin
      p9 <= p8;
      f9 <= f8;
      if (f8.mx < 30'd536870912) begin
        f9.mx <= f8.mx << 1;
        for (int i = 0; i < 3; i++) begin
          p9.mn[i] <= p8.mn[i] << 1;
        end
      end
      p9.tir <= (p8.mode == MODE_REFRACT) && f8.k[31];
    end
  end

  // Stage 10: squares of the normalized or prescaled magnitudes.
  always_ff @(posedge clk) begin
    if (adv) begin
      p10 <= p9;
      for (int i = 0; i < 3; i++) begin
        if (p9.mode == MODE_DIR) begin
          s10_sq[i] <= 64'(p9.mn[i]) * 64'(p9.mn[i]);
        end else begin
          s10_sq[i] <= 64'(f9.m4[i]) * 64'(f9.m4[i]);
        end
      end
      s10_k <= f9.k;
    end
  end

  // Stage 11: pick the radicand for the shared square root chain.
  always_ff @(posedge clk) begin
    if (adv) begin
      p11 <= p10;
      if ((p10.mode == MODE_DIR) || (p10.mode == MODE_LENGTH)) begin
        s11_rad <= s10_sq[0] + s10_sq[1] + s10_sq[2];
      end else if ((p10.mode == MODE_REFRACT) && !p10.tir) begin
        s11_rad <= RVU_RAD_W'(s10_k) << FRAC_BITS;
      end else begin
        s11_rad <= '0;
      end
    end
  end

  assign sq_v[0]    = v[10];
  assign sq_rem[0]  = s11_rad;
  assign sq_root[0] = '0;
  assign sq_side[0] = p11;

  for (genvar j = 0; j < RVU_ROOT_W; j++) begin : g_sqrt
    rvu_sqrt_cell #(.STEP(RVU_ROOT_W - 1 - j)) u_cell (
      .clk      (clk),
      .rst      (rst),
      .adv      (adv),
      .in_valid (sq_v[j]),
      .in_rem   (sq_rem[j]),
      .in_root  (sq_root[j]),
      .in_side  (sq_side[j]),
      .out_valid(sq_v[j+1]),
      .out_rem  (sq_rem[j+1]),
      .out_root (sq_root[j+1]),
      .out_side (sq_side[j+1])
    );
  end

  assign dv_v[0]    = sq_v[RVU_ROOT_W];
  assign dv_len[0]  = sq_root[RVU_ROOT_W];
  assign dv_side[0] = sq_side[RVU_ROOT_W];
  assign dv_quo[0]  = '0;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      dv_rem[0][i] = RW'(sq_side[RVU_ROOT_W].mn[i]) << FRAC_BITS;
    end
  end

  for (genvar j = 0; j <= FRAC_BITS; j++) begin : g_div
    rvu_div_cell #(.FRAC_BITS(FRAC_BITS), .STEP(FRAC_BITS - j)) u_cell (
      .clk      (clk),
      .rst      (rst),
      .adv      (adv),
      .in_valid (dv_v[j]),
      .in_len   (dv_len[j]),
      .in_rem   (dv_rem[j]),
      .in_quo   (dv_quo[j]),
      .in_side  (dv_side[j]),
      .out_valid(dv_v[j+1]),
      .out_len  (dv_len[j+1]),
      .out_rem  (dv_rem[j+1]),
      .out_quo  (dv_quo[j+1]),
      .out_side (dv_side[j+1])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
      vb <= 1'b0;
    end else if (adv) begin
      va <= dv_v[ND-1];
      vb <= va;
    end
  end

  // Post stage A: refraction coefficient s*c - sqrt(k).
  // Post stage B: coefficient times the normal.
  always_ff @(posedge clk) begin
    if (adv) begin
      a_coef <= sat32(66'($signed(dv_side[ND-1].qsc)) - $signed(66'(dv_len[ND-1])));
      a_root <= dv_len[ND-1];
      a_quo  <= dv_quo[ND-1];
      a_side <= dv_side[ND-1];
      for (int i = 0; i < 3; i++) begin
        b_pcb[i] <= a_coef * $signed(a_side.b[i]);
      end
      b_root <= a_root;
      b_quo  <= a_quo;
      b_side <= a_side;
    end
  end

  // Final formatting per mode, written straight into the result buffer.
  always_comb begin
    logic signed [31:0] r [3];
    logic [32:0]        lw;
    lw     = 33'(b_root) << b_side.sh;
    fmt    = '0;
    r[0]   = '0;
    r[1]   = '0;
    r[2]   = '0;
    unique case (b_side.mode)
      MODE_DIR: begin
        if (!b_side.zero) begin
          for (int i = 0; i < 3; i++) begin
            r[i] = b_side.neg[i] ? -$signed(32'(b_quo[i])) : $signed(32'(b_quo[i]));
          end
        end
      end
      MODE_REFRACT: begin
        if (!b_side.tir) begin
          for (int i = 0; i < 3; i++) begin
            r[i] = sat32(66'($signed(b_side.qsa[i]))
                         + 66'(sat32(66'(b_pcb[i] >>> FRAC_BITS))));
          end
        end
      end
      MODE_REFLECT, MODE_POINT: begin
        for (int i = 0; i < 3; i++) begin
          r[i] = $signed(b_side.res[i]);
        end
      end
      MODE_LENGTH: begin
        fmt.length = (lw > 33'h07FFFFFFF) ? 31'h7FFFFFFF : lw[30:0];
      end
      default: begin
        fmt.length = '0;
      end
    endcase
    fmt.x   = r[0];
    fmt.y   = r[1];
    fmt.z   = r[2];
    fmt.tir = b_side.tir;
  end

  assign push = adv && vb;
  assign pop  = rsp.valid && rsp.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else begin
      cnt <= cnt + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk) begin
    unique case ({push, pop})
      2'b10: begin
        if (cnt == 2'd0) begin
          q0 <= fmt;
        end else begin
          q1 <= fmt;
        end
      end
      2'b01: begin
        q0 <= q1;
      end
      2'b11: begin
        if (cnt == 2'd1) begin
          q0 <= fmt;
        end else begin
          q0 <= q1;
          q1 <= fmt;
        end
      end
      default: begin
        q0 <= q0;
      end
    endcase
  end

  assign rsp.valid          = (cnt != 2'd0);
  assign rsp.res_x          = q0.x;
  assign rsp.res_y          = q0.y;
  assign rsp.res_z          = q0.z;
  assign rsp.res_length     = q0.length;
  assign rsp.total_internal = q0.tir;

endmodule

`default_nettype wire

[sv/rvu_checker.sv]
// Port-level checks for the ray vector unit, bound to the top level.
// Depends on ray_vector_unit and its channel interfaces.
`default_nettype none

module rvu_checker (
  input logic               clk,
  input logic               rst,
  input logic               req_ready,
  input logic               rsp_valid,
  input logic               rsp_ready,
  input logic signed [31:0] res_x,
  input logic signed [31:0] res_y,
  input logic signed [31:0] res_z,
  input logic [30:0]        res_length,
  input logic               total_internal
);

  // A result that is not taken stays offered.
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid)
    else $error("result withdrawn before it was taken");

  // Total internal reflection always comes with a zero vector and no length.
  a_tir_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && total_internal |->
      res_x == 0 && res_y == 0 && res_z == 0 && res_length == 0)
    else $error("total internal reflection with nonzero result");

  // A length result carries no vector.
  a_len_only: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && res_length != 0 |-> res_x == 0 && res_y == 0 && res_z == 0)
    else $error("length result with nonzero vector");

  // Requests are refused only while a result waits and is not taken.
  a_backpressure: assert property (@(posedge clk) disable iff (rst)
    !req_ready |-> rsp_valid && !rsp_ready)
    else $error("request refused without output back pressure");

endmodule

bind ray_vector_unit rvu_checker u_rvu_checker (
  .clk           (clk),
  .rst           (rst),
  .req_ready     (req.ready),
  .rsp_valid     (rsp.valid),
  .rsp_ready     (rsp.ready),
  .res_x         (rsp.res_x),
  .res_y         (rsp.res_y),
  .res_z         (rsp.res_z),
  .res_length    (rsp.res_length),
  .total_internal(rsp.total_internal)
);

`default_nettype wire
